[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Every check is sampled on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define UPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define UPD_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[hw/rtl/upd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CASE_GAP   = 8'h20;   // 'a' - 'A'
    localparam logic [7:0] ALPHA_BIAS = 8'd55;   // 'A' - 10

    // One decoded run: up to three characters, emitted c0 first
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] c2;
        logic [7:0] c1;
        logic [7:0] c0;
    } upd_run_t;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } upd_q_status_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [7:0] hex_val(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (u >= 8'h61)
        begin
            u = u - CASE_GAP;
        end
        if (u >= 8'h41)
        begin
            hex_val = u - ALPHA_BIAS;
        end
        else
        begin
            hex_val = u - CHAR_ZERO;
        end
    endfunction

endpackage

`default_nettype wire

[hw/rtl/upd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module upd_front
    import upd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_char,
    input  wire upd_q_status_t q_status,
    output logic               push,
    output upd_run_t           push_run
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       accept;
    logic       nul_taken;
    logic       c_hex;
    logic       idle_pct;
    logic [7:0] idle_out;
    logic [1:0] idle_cnt;
    upd_run_t   run;

    assign in_ready  = !q_status.full;
    assign accept    = in_valid && in_ready;
    assign nul_taken = accept && (in_char == CHAR_NUL);

    // Classify the incoming character as it would be seen with nothing held
    assign c_hex    = (in_char != CHAR_NUL) && is_hex(in_char);
    assign idle_pct = (in_char == CHAR_PCT);
    assign idle_out = (in_char == CHAR_PLUS) ? CHAR_SPACE : in_char;
    assign idle_cnt = idle_pct ? 2'd0 : 2'd1;

    // Build the run of output characters and the next escape state
    always_comb
    begin
        run        = '0;
        phase_next = idle_pct ? PH_PCT : PH_IDLE;
        held_next  = held_reg;
        case (phase_reg)
            PH_PCT:
            begin
                if (c_hex)
                begin
                    held_next  = in_char;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    run.c0  = CHAR_PCT;
                    run.c1  = idle_out;
                    run.cnt = 2'd1 + idle_cnt;
                end
            end
            PH_DIGIT:
            begin
                if (c_hex)
                begin
                    run.c0     = 8'((hex_val(held_reg) << 4) + hex_val(in_char));
                    run.cnt    = 2'd1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    run.c0  = CHAR_PCT;
                    run.c1  = held_reg;
                    run.c2  = idle_out;
                    run.cnt = 2'd2 + idle_cnt;
                end
            end
            default:
            begin
                run.c0  = idle_out;
                run.cnt = idle_cnt;
            end
        endcase
    end

    assign push     = accept && (run.cnt != 2'd0);
    assign push_run = run;

    // Advance the escape state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    `UPD_ASSERT_NEXT(a_nul_ends_escape, nul_taken, phase_reg == PH_IDLE, "escape held past end")
    `UPD_ASSERT(a_no_push_when_full, push |-> !q_status.full, "run pushed into full queue")

endmodule

`default_nettype wire

[hw/rtl/upd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module upd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire upd_run_t push_run,
    input  wire logic     pop,
    output upd_run_t      head,
    output upd_q_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    upd_run_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold run records
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_run;
        end
    end

    `UPD_ASSERT(a_no_underflow, pop |-> !status.empty, "pop from empty queue")
    `UPD_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

[hw/rtl/upd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module upd_back
    import upd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire upd_run_t      head,
    input  wire upd_q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_char,
    output logic               last_of_run
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    logic       load;
    logic       at_last;
    logic [7:0] sel_char;

    assign load    = (!out_valid_reg || out_ready) && !q_status.empty;
    assign at_last = (idx_reg == (head.cnt - 2'd1));
    assign pop     = load && at_last;

    // Pick the next character of the head run
    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_char = head.c0;
            2'd1:    sel_char = head.c1;
            default: sel_char = head.c2;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = at_last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output payload until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= sel_char;
            out_last_reg <= at_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign last_of_run = out_last_reg;

    `UPD_ASSERT(a_idx_in_run, !q_status.empty |-> (idx_reg < head.cnt), "run index past run")
    `UPD_ASSERT(a_idx_zero_idle, q_status.empty |-> (idx_reg == 2'd0), "stale run index")

endmodule

`default_nettype wire

[hw/rtl/url_percent_decoder.sv]
// Streaming form-urlencoded decoder, one character per item.
// Input channel: in_valid / in_ready / in_char. Output channel: out_valid /
// out_ready / out_char / last_of_run. "%XY" (hex, either case) becomes one
// byte, '+' becomes a space, other bytes pass. A broken escape releases the
// held '%' and digit literally, then the breaking character is handled anew.
// in_char of zero flushes anything held and yields a zero terminator.
// An item yields 0 to 3 results; last_of_run marks the final one.
// The first result of an item passes through the run queue (written by
// the accepting edge) and then the output register before it is valid.
// Throughput: one item per cycle while each item yields at most one result
// and out_ready stays high. The output register emits one result per cycle
// while out_ready is high, so an item that yields two or three results
// holds it while each is emitted in turn; the run queue (QUEUE_DEPTH runs)
// absorbs this and in_ready drops only when it is full.
// A stalled receiver holds the output register; the queue then fills and
// in_ready falls. Reset clears the escape state, the queue and out_valid.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_char,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_char,
    output logic            last_of_run
);

    upd_q_status_t q_status;
    upd_run_t      push_run;
    upd_run_t      head;
    logic          push;
    logic          pop;

    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_char  (in_char),
        .q_status (q_status),
        .push     (push),
        .push_run (push_run)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    upd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
